// ===== hw/rtl/b64le_pkg.sv =====
`timescale 1ns / 1ps

package b64le_pkg;

    localparam logic [7:0] LINE_LIMIT_RESET = 8'd120;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [6:0] CHAR_NEWLINE = 7'h0a;
    localparam logic [6:0] CHAR_PAD     = 7'h3d;

    localparam logic [2:0] IDX_NEWLINE  = 3'd4;
    localparam logic [2:0] IDX_LAST_SYM = 3'd3;

    // one encoding job: a group of up to three bytes plus what follows it
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  pads;
        logic        has_nl;
        logic        done;
    } t_job;

    // base64 alphabet lookup
    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] c;
        c = {1'b0, v};
        if (v < 6'd26) begin
            b64_char = c + 7'd65;
        end else if (v < 6'd52) begin
            b64_char = c + 7'd71;
        end else if (v < 6'd62) begin
            b64_char = c - 7'd4;
        end else if (v == 6'd62) begin
            b64_char = 7'h2b;
        end else begin
            b64_char = 7'h2f;
        end
    endfunction

endpackage

// ===== hw/rtl/b64le_in_if.sv =====
`timescale 1ns / 1ps

interface b64le_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_message;

    modport source (output valid, output in_byte, output end_of_message, input ready);
    modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

// ===== hw/rtl/b64le_out_if.sv =====
`timescale 1ns / 1ps

interface b64le_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       run_last;
    logic       message_done;

    modport source (output valid, output out_char, output run_last, output message_done,
                    input ready);
    modport sink   (input valid, input out_char, input run_last, input message_done,
                    output ready);
endinterface

// ===== hw/rtl/b64le_front.sv =====
`timescale 1ns / 1ps

module b64le_front
    import b64le_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_ready,
    input  logic       i_q_full,
    output logic       o_push,
    output t_job       o_job
);

    logic [7:0]  r_limit;
    logic [15:0] r_pend;
    logic [1:0]  r_cnt;
    logic [7:0]  r_line;

    logic [15:0] n_pend;
    logic [1:0]  n_cnt;
    logic [7:0]  n_line;

    logic [8:0]  sum;
    logic        hit;
    logic        accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign sum     = {1'b0, r_line} + 9'd4;
    assign hit     = sum >= {1'b0, r_limit};

    always_comb begin
        n_pend       = r_pend;
        n_cnt        = r_cnt;
        n_line       = r_line;
        o_job.word   = {i_byte, 16'h0000};
        o_job.pads   = 2'd2;
        o_job.has_nl = 1'b1;
        o_job.done   = i_last;
        case (r_cnt)
            2'd2: begin
                o_job.word   = {r_pend, i_byte};
                o_job.pads   = 2'd0;
                o_job.has_nl = hit || i_last;
                n_line       = hit ? 8'd0 : sum[7:0];
                n_cnt        = 2'd0;
                n_pend       = 16'h0000;
            end
            2'd1: begin
                o_job.word = {r_pend[15:8], i_byte, 8'h00};
                o_job.pads = 2'd1;
                n_pend     = {r_pend[15:8], i_byte};
                n_cnt      = 2'd2;
            end
            default: begin
                n_pend = {i_byte, 8'h00};
                n_cnt  = 2'd1;
            end
        endcase
        if (i_last) begin
            n_pend = 16'h0000;
            n_cnt  = 2'd0;
            n_line = 8'd0;
        end
    end

    // a job leaves only for a full group or the final byte
    assign o_push = accept && ((r_cnt == 2'd2) || i_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LINE_LIMIT_RESET;
            r_pend  <= 16'h0000;
            r_cnt   <= 2'd0;
            r_line  <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (accept) begin
                r_pend <= n_pend;
                r_cnt  <= n_cnt;
                r_line <= n_line;
            end
        end
    end

endmodule

// ===== hw/rtl/b64le_queue.sv =====
`timescale 1ns / 1ps

module b64le_queue
    import b64le_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_pop;
    logic          do_push;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;
    assign do_push = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/b64le_back.sv =====
`timescale 1ns / 1ps

module b64le_back
    import b64le_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [6:0] o_char,
    output logic       o_run_last,
    output logic       o_done
);

    logic       r_busy;
    t_job       r_job;
    logic [2:0] r_idx;

    logic       final_char;
    logic       take;
    logic       load;

    assign final_char = (r_idx == IDX_NEWLINE) || (r_idx == IDX_LAST_SYM && !r_job.has_nl);
    assign take       = r_busy && i_ready;
    assign load       = !r_busy || (take && final_char);
    assign o_pop      = load && i_q_valid;

    always_comb begin
        case (r_idx)
            3'd0: o_char = b64_char(r_job.word[23:18]);
            3'd1: o_char = b64_char(r_job.word[17:12]);
            3'd2: o_char = (r_job.pads == 2'd2) ? CHAR_PAD : b64_char(r_job.word[11:6]);
            3'd3: o_char = (r_job.pads != 2'd0) ? CHAR_PAD : b64_char(r_job.word[5:0]);
            default: o_char = CHAR_NEWLINE;
        endcase
    end

    assign o_valid    = r_busy;
    assign o_run_last = final_char;
    assign o_done     = final_char && r_job.done;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (load) begin
            r_busy <= i_q_valid;
            r_idx  <= 3'd0;
        end else if (take) begin
            r_idx <= r_idx + 3'd1;
        end
    end

endmodule

// ===== hw/rtl/base64_line_wrapped_encoder.sv =====
// path: a byte that completes a group is queued, then loaded into the emitter's job register
// throughput: one byte per cycle in while the queue has room; one char per cycle out if ready
// sustained rate is set by the single-character output: 4 or 5 characters per 3-byte group
// reset: synchronous active-low i_rst_n clears group, line count and queue; line_limit to 120
`timescale 1ns / 1ps

module base64_line_wrapped_encoder
    import b64le_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_data,
    b64le_in_if.sink     i_in,
    b64le_out_if.source  o_out
);

    // jobs from the byte collector to the character emitter
    t_job q_in_job;
    t_job q_out_job;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;

    // front: collects bytes into groups, tracks line length, builds jobs
    b64le_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_in.valid),
        .i_byte     (i_in.in_byte),
        .i_last     (i_in.end_of_message),
        .o_ready    (i_in.ready),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (q_in_job)
    );

    // short queue so the input keeps flowing while characters drain
    b64le_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    // back: emits four symbols and an optional newline per job
    b64le_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_job      (q_out_job),
        .o_pop      (q_pop),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_char     (o_out.out_char),
        .o_run_last (o_out.run_last),
        .o_done     (o_out.message_done)
    );

endmodule

// ===== hw/rtl/b64le_checker.sv =====
`timescale 1ns / 1ps

module b64le_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_out_char,
    input logic       i_out_run_last,
    input logic       i_out_done
);

    localparam logic [6:0] NL = 7'h0a;

    // message end is always the last character of its item
    a_done_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_done |-> i_out_run_last)
        else $error("message_done without run_last");

    // a message always closes with a newline
    a_done_is_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_done |-> i_out_char == NL)
        else $error("message does not end with newline");

    // stalled output holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char))
        else $error("stalled output changed");

    // nothing comes out right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind base64_line_wrapped_encoder b64le_checker u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_char     (o_out.out_char),
    .i_out_run_last (o_out.run_last),
    .i_out_done     (o_out.message_done)
);
